@@ rtl/isp_pkg.sv @@
// Shared types and constants, including the hash constants, for the inode set probe unit.
package isp_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam logic [63:0] HASH_MUL = 64'd1099511628211;
	localparam logic [63:0] HASH_ADD = 64'h9e3779b97f4a7c15;

	localparam logic ACT_QUERY = 1'b0;
	localparam logic ACT_ADD = 1'b1;

	typedef struct packed {
		logic        action;
		logic [63:0] inode;
		logic [63:0] device;
	} req_t;

	typedef struct packed {
		logic present;
		logic added;
		logic full_res;
	} res_t;

	// hashed request handed from front to back
	typedef struct packed {
		logic        action;
		logic [63:0] inode;
		logic [63:0] device;
		logic [63:0] hash;
	} job_t;

endpackage

@@ rtl/isp_front.sv @@
// Front end: accepts requests and computes the probe hash over two stages.
module isp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  isp_pkg::req_t in_req,
	output logic          job_valid,
	input  logic          job_ready,
	output isp_pkg::job_t job
);

	logic          v_s1_q, v_s2_q;
	isp_pkg::req_t req_s1;
	logic [63:0]   prod_s1;
	isp_pkg::job_t job_s2;
	logic          adv_s2, adv_s1;

	assign adv_s2 = !v_s2_q || job_ready;
	assign adv_s1 = !v_s1_q || adv_s2;
	assign in_ready = adv_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			if (adv_s2) v_s2_q <= v_s1_q;
			if (adv_s1) v_s1_q <= in_valid;
		end
	end

	// stage 1: low 64 bits of the product from three 32-bit partial products
	logic [63:0] p_ll, p_lh, p_hl;
	logic [63:0] p_ll_s1, p_cross_s1;
	assign p_ll = {32'd0, in_req.inode[31:0]} * {32'd0, isp_pkg::HASH_MUL[31:0]};
	assign p_lh = {32'd0, in_req.inode[31:0]} * {32'd0, isp_pkg::HASH_MUL[63:32]};
	assign p_hl = {32'd0, in_req.inode[63:32]} * {32'd0, isp_pkg::HASH_MUL[31:0]};
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			req_s1     <= in_req;
			p_ll_s1    <= p_ll;
			p_cross_s1 <= p_lh + p_hl;
		end
	end
	assign prod_s1 = p_ll_s1 + {p_cross_s1[31:0], 32'd0};

	// stage 2: mix with device
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			job_s2.action <= req_s1.action;
			job_s2.inode  <= req_s1.inode;
			job_s2.device <= req_s1.device;
			job_s2.hash   <= prod_s1 ^ (req_s1.device + isp_pkg::HASH_ADD
				+ {prod_s1[57:0], 6'd0} + {2'd0, prod_s1[63:2]});
		end
	end

	assign job_valid = v_s2_q;
	assign job = job_s2;

endmodule

@@ rtl/isp_queue.sv @@
// Two-entry queue between front and back end.
module isp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  isp_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output isp_pkg::job_t rd_data
);

	isp_pkg::job_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !rd) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !rd)
		else $error("read from empty queue");

endmodule

@@ rtl/isp_back.sv @@
// Back end: clears the table, probes linearly and stores new pairs.
module isp_back #(
	parameter int CAPACITY = isp_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  isp_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_ready,
	output isp_pkg::res_t res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;
	localparam logic [CW+1:0] LIMIT = (CW+2)'(CAPACITY * 3);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  idx_q;
	logic [CW-1:0]  probes_q, count_q;
	isp_pkg::job_t  cur_q;
	logic           used_mem [CAPACITY];
	logic [127:0]   pair_mem [CAPACITY];
	logic           used_rd_q;
	logic [127:0]   pair_rd_q;
	logic           res_v_q;
	isp_pkg::res_t  res_q;
	isp_pkg::res_t  done_res_q;
	logic           hit, store, at_limit, post;

	assign job_ready = state_q == ST_IDLE;
	assign res_valid = res_v_q;
	assign res = res_q;
	assign hit = used_rd_q && pair_rd_q == {cur_q.inode, cur_q.device};
	assign at_limit = {count_q + CW'(1), 2'b00} >= LIMIT;
	assign store = state_q == ST_CHECK && !used_rd_q && cur_q.action == isp_pkg::ACT_ADD
		&& !at_limit;
	// finished result moves to the output once the previous one is gone
	assign post = state_q == ST_DONE && (!res_v_q || res_ready);

	// memory ports: one write, one registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) used_mem[idx_q] <= 1'b0;
		else if (store) begin
			used_mem[idx_q] <= 1'b1;
			pair_mem[idx_q] <= {cur_q.inode, cur_q.device};
		end
		used_rd_q <= used_mem[idx_q];
		pair_rd_q <= pair_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) cur_q <= job;
	end

	// probe sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			idx_q      <= '0;
			probes_q   <= '0;
			count_q    <= '0;
			res_v_q    <= 1'b0;
			res_q      <= '0;
			done_res_q <= '0;
		end else begin
			if (post) res_v_q <= 1'b1;
			else if (res_ready) res_v_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == AW'(CAPACITY - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (job_valid) begin
						idx_q    <= job.hash[AW-1:0];
						probes_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					probes_q <= probes_q + CW'(1);
					if (!used_rd_q || hit || probes_q == CW'(CAPACITY - 1)) begin
						done_res_q.present  <= hit;
						done_res_q.added    <= store;
						done_res_q.full_res <= cur_q.action == isp_pkg::ACT_ADD
							&& !hit && !store;
						if (store) count_q <= count_q + CW'(1);
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (post) begin
						res_q   <= done_res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		store |=> count_q == $past(count_q) + CW'(1))
		else $error("entry count did not follow store");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid && $stable(res))
		else $error("waiting result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_q.added && res_valid) |-> !res_q.present && !res_q.full_res)
		else $error("conflicting result flags");

endmodule

@@ rtl/inode_set_linear_probe_unit.sv @@
// Path: the hash stages, the two-entry queue, then a read state and a check state per slot probed, then done.
// The back end takes a new request only once it is idle again, after it has posted the last result.
// The hash front runs ahead through a two-entry queue while the back end probes.
// After reset the used marks are cleared, one slot a cycle, and the back end takes nothing until
// the whole table is clear, so full rises once the front and queue hold four requests.
// Reset is asynchronous, active low, and empties the front stages, the queue and the entry count.
module inode_set_linear_probe_unit #(
	parameter int CAPACITY = isp_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  isp_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output isp_pkg::res_t res
);

	logic          in_ready, f_valid, f_ready, b_valid, b_ready, r_valid;
	isp_pkg::job_t f_job, b_job;

	assign full = !in_ready;
	assign empty = !r_valid;

	isp_front u_front (
		.clk, .arst_n, .in_valid(push), .in_ready, .in_req(req),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	isp_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
	);

	isp_back #(.CAPACITY(CAPACITY)) u_back (
		.clk, .arst_n, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
		.res_valid(r_valid), .res_ready(pop), .res
	);

endmodule

@@ sim/tb_inode_set_linear_probe_unit.sv @@
// Testbench for the inode set probe unit: directed and random query/add requests checked
// against a behavioral hash set model.
module tb_inode_set_linear_probe_unit;

	localparam int CAP = isp_pkg::CAPACITY_DEF;
	localparam int LIMIT_CYCLES = 5000000;

	logic          clk;
	logic          arst_n;
	logic          push;
	logic          full;
	isp_pkg::req_t req;
	logic          empty;
	logic          pop;
	isp_pkg::res_t res;

	inode_set_linear_probe_unit #(.CAPACITY(CAP)) u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .res(res)
	);

	// model of the set
	logic          mdl_used[CAP];
	logic [63:0]   mdl_inode[CAP];
	logic [63:0]   mdl_device[CAP];
	int            mdl_count;
	isp_pkg::res_t expected_res[$];
	int            errors;
	int            cycle_cnt;
	int            hold_cycles;
	int            burst_len;

	// known pairs, reused so adds hit present and queries hit stored entries
	logic [63:0] known_inode[$];
	logic [63:0] known_device[$];

	function automatic logic [63:0] slot_hash(logic [63:0] ino, logic [63:0] dev);
		logic [63:0] h;
		logic [63:0] t;
		h = ino * isp_pkg::HASH_MUL;
		t = dev + isp_pkg::HASH_ADD + (h << 6) + (h >> 2);
		return h ^ t;
	endfunction

	// walk the probe sequence and update the model
	function automatic isp_pkg::res_t set_access(isp_pkg::req_t r);
		isp_pkg::res_t o;
		int idx;
		int hole;
		bit found;
		idx = int'(slot_hash(r.inode, r.device) & 64'(CAP - 1));
		hole = -1;
		found = 0;
		for (int n = 0; n < CAP; n++) begin
			if (!mdl_used[idx]) begin
				hole = idx;
				break;
			end
			if (mdl_inode[idx] == r.inode && mdl_device[idx] == r.device) begin
				found = 1;
				break;
			end
			idx = (idx + 1) & (CAP - 1);
		end
		o = '0;
		o.present = found;
		if (r.action == isp_pkg::ACT_ADD && !found) begin
			if ((mdl_count + 1) * 4 >= CAP * 3 || hole < 0) begin
				o.full_res = 1'b1;
			end else begin
				mdl_used[hole] = 1'b1;
				mdl_inode[hole] = r.inode;
				mdl_device[hole] = r.device;
				mdl_count++;
				o.added = 1'b1;
			end
		end
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// timeout
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: random stall pattern, long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			pop <= 1'b0;
		end else begin
			pop <= (cycle_cnt % 64 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// result check
	always @(posedge clk) begin
		isp_pkg::res_t exp_r;
		if (arst_n && pop && !empty) begin
			if (expected_res.size() == 0) begin
				$display("%0t: unexpected result %b", $time, res);
				errors++;
			end else begin
				exp_r = expected_res.pop_front();
				if (res.present !== exp_r.present)
					$display("%0t: present exp %b got %b", $time, exp_r.present,
						res.present);
				if (res.added !== exp_r.added)
					$display("%0t: added exp %b got %b", $time, exp_r.added, res.added);
				if (res.full_res !== exp_r.full_res)
					$display("%0t: full_res exp %b got %b", $time, exp_r.full_res,
						res.full_res);
				if (res !== exp_r)
					errors++;
			end
		end
	end

	// send one request, with burst/gap pacing
	task automatic send_req(logic act, logic [63:0] ino, logic [63:0] dev);
		isp_pkg::req_t r;
		r.action = act;
		r.inode = ino;
		r.device = dev;
		if (burst_len == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(0, 6)) @(posedge clk);
			burst_len = $urandom_range(1, 20);
		end
		burst_len--;
		push <= 1'b1;
		req <= r;
		do @(posedge clk); while (full);
		expected_res.push_back(set_access(r));
		if (act == isp_pkg::ACT_ADD) begin
			known_inode.push_back(ino);
			known_device.push_back(dev);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_res.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_extremes();
		send_req(isp_pkg::ACT_QUERY, '0, '0);
		send_req(isp_pkg::ACT_ADD, '0, '0);
		send_req(isp_pkg::ACT_ADD, '0, '0);
		send_req(isp_pkg::ACT_QUERY, '0, '0);
		send_req(isp_pkg::ACT_ADD, '1, '1);
		send_req(isp_pkg::ACT_QUERY, '1, '1);
		send_req(isp_pkg::ACT_QUERY, '1, '0);
		send_req(isp_pkg::ACT_ADD, '0, '1);
		send_req(isp_pkg::ACT_ADD, '1, '0);
		send_req(isp_pkg::ACT_ADD, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		send_req(isp_pkg::ACT_QUERY, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		// colliding start slots: same inode, devices differing only above the low ten bits
		for (int i = 0; i < 6; i++)
			send_req(isp_pkg::ACT_ADD, 64'd77, 64'(i) << 10);
		for (int i = 0; i < 6; i++)
			send_req(isp_pkg::ACT_QUERY, 64'd77, 64'(i) << 10);
		drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 30; i++)
			send_req($urandom_range(0, 1), rand64(), rand64());
		drain();
	endtask

	task automatic test_random(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			if (k < 4 && known_inode.size() > 0) begin
				k = $urandom_range(0, known_inode.size() - 1);
				send_req($urandom_range(0, 1), known_inode[k], known_device[k]);
			end else if (k < 6) begin
				send_req(isp_pkg::ACT_QUERY, rand64(), rand64());
			end else begin
				send_req(isp_pkg::ACT_ADD, rand64(), rand64());
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		req = '0;
		errors = 0;
		cycle_cnt = 0;
		hold_cycles = 0;
		burst_len = 0;
		mdl_count = 0;
		for (int i = 0; i < CAP; i++) begin
			mdl_used[i] = 1'b0;
			mdl_inode[i] = '0;
			mdl_device[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_backpressure();
		// random mix of queries and adds over new and known pairs
		test_random(1400);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/isp_pkg.sv
rtl/isp_front.sv
rtl/isp_queue.sv
rtl/isp_back.sv
rtl/inode_set_linear_probe_unit.sv
sim/tb_inode_set_linear_probe_unit.sv
